FILE: rtl/core/hps_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the heap sorter core.
// No dependencies; imported by hps_cell and heap_sorter_core.
package hps_pkg;

	// Default number of values one set may hold.
	localparam int DEF_CAPACITY = 64;

	// Default width of one signed value.
	localparam int DEF_VALUE_WIDTH = 16;

endpackage

FILE: rtl/core/hps_cell.sv
`timescale 1ns / 1ps
// One cell of the sorting chain: holds one value and passes the larger one on.
// Depends on hps_pkg for the default value width.
module hps_cell #(
	parameter int VALUE_WIDTH = hps_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift_en,
	input  logic signed [VALUE_WIDTH-1:0] in_value,
	input  logic                          in_valid,
	input  logic signed [VALUE_WIDTH-1:0] right_value,
	input  logic                          right_valid,
	output logic signed [VALUE_WIDTH-1:0] held_value,
	output logic                          held_valid,
	output logic signed [VALUE_WIDTH-1:0] carry_value,
	output logic                          carry_valid
);
	import hps_pkg::*;

	logic signed [VALUE_WIDTH-1:0] held_value_q;
	logic                          held_valid_q;
	logic signed [VALUE_WIDTH-1:0] carry_value_q;
	logic                          carry_valid_q;

	// Occupancy of the cell and of its outgoing carry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q  <= 1'b0;
			carry_valid_q <= 1'b0;
		end else if (shift_en) begin
			held_valid_q  <= right_valid;
			carry_valid_q <= 1'b0;
		end else begin
			carry_valid_q <= in_valid && held_valid_q;
			if (in_valid) begin
				held_valid_q <= 1'b1;
			end
		end
	end

	// The cell keeps the smaller value and hands the other one to its right neighbour.
	// On equal values the arriving one moves on.
	always_ff @(posedge clk) begin
		if (shift_en) begin
			held_value_q <= right_value;
		end else if (in_valid) begin
			if (!held_valid_q) begin
				held_value_q <= in_value;
			end else if (in_value < held_value_q) begin
				held_value_q  <= in_value;
				carry_value_q <= held_value_q;
			end else begin
				carry_value_q <= in_value;
			end
		end
	end

	assign held_value  = held_value_q;
	assign held_valid  = held_valid_q;
	assign carry_value = carry_value_q;
	assign carry_valid = carry_valid_q;

endmodule

FILE: rtl/core/heap_sorter_core.sv
`timescale 1ns / 1ps
// Sorting core: a chain of CAPACITY cells that returns each set of values in ascending order.
// Depends on hps_pkg and hps_cell.
// Values load one per cycle. After the transfer marked last the core waits in a drain state
// while the final insertion ripples down the chain, one cell a cycle; results then leave at
// one per cycle from the head cell while the receiver does not stall.
// Reset empties every cell and returns the core to loading with no values and no overflow.
module heap_sorter_core #(
	parameter int CAPACITY    = hps_pkg::DEF_CAPACITY,
	parameter int VALUE_WIDTH = hps_pkg::DEF_VALUE_WIDTH
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          valid,
	output logic                          stall,
	input  logic signed [VALUE_WIDTH-1:0] value,
	input  logic                          last,
	output logic                          valid_res,
	input  logic                          stall_res,
	output logic signed [VALUE_WIDTH-1:0] value_res,
	output logic                          last_res,
	output logic                          overflow
);
	import hps_pkg::*;

	localparam int CountWidth = $clog2(CAPACITY + 1);
	localparam int DrainWidth = $clog2(CAPACITY);

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_DRAIN,
		ST_EMIT
	} state_t;

	state_t                state_q;
	logic [CountWidth-1:0] count_q;
	logic [DrainWidth-1:0] drain_q;
	logic                  dropped_q;

	logic in_xfer;
	logic out_xfer;
	logic store_full;
	logic ins_valid;

	logic signed [VALUE_WIDTH-1:0] cell_value  [CAPACITY];
	logic                          cell_valid  [CAPACITY];
	logic signed [VALUE_WIDTH-1:0] carry_value [CAPACITY];
	logic                          carry_valid [CAPACITY];

	// Handshake decode.
	assign stall      = (state_q != ST_LOAD);
	assign in_xfer    = valid && !stall;
	assign valid_res  = (state_q == ST_EMIT);
	assign out_xfer   = valid_res && !stall_res;
	assign store_full = (count_q == CountWidth'(CAPACITY));
	assign ins_valid  = in_xfer && !store_full;

	// Sequencer: load values, let the chain settle, then stream the sorted values out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_LOAD;
			count_q   <= '0;
			drain_q   <= '0;
			dropped_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_LOAD: begin
					if (in_xfer) begin
						if (store_full) begin
							dropped_q <= 1'b1;
						end else begin
							count_q <= count_q + CountWidth'(1);
						end
						if (last) begin
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end
					end
				end
				ST_DRAIN: begin
					if (drain_q == DrainWidth'(CAPACITY - 1)) begin
						state_q <= ST_EMIT;
					end else begin
						drain_q <= drain_q + DrainWidth'(1);
					end
				end
				ST_EMIT: begin
					if (out_xfer) begin
						if (count_q == CountWidth'(1)) begin
							count_q   <= '0;
							dropped_q <= 1'b0;
							state_q   <= ST_LOAD;
						end else begin
							count_q <= count_q - CountWidth'(1);
						end
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Result fields come straight from the head cell and the sequencer registers.
	assign value_res = cell_value[0];
	assign last_res  = (count_q == CountWidth'(1));
	assign overflow  = dropped_q;

	// The chain of cells: inserts enter on the left, results leave on the left.
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_WIDTH-1:0] left_value;
		logic                          left_valid;
		logic signed [VALUE_WIDTH-1:0] nb_value;
		logic                          nb_valid;

		if (i == 0) begin : g_head
			assign left_value = value;
			assign left_valid = ins_valid;
		end else begin : g_body
			assign left_value = carry_value[i-1];
			assign left_valid = carry_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_tail
			assign nb_value = '0;
			assign nb_valid = 1'b0;
		end else begin : g_inner
			assign nb_value = cell_value[i+1];
			assign nb_valid = cell_valid[i+1];
		end

		hps_cell #(
			.VALUE_WIDTH(VALUE_WIDTH)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift_en   (out_xfer),
			.in_value   (left_value),
			.in_valid   (left_valid),
			.right_value(nb_value),
			.right_valid(nb_valid),
			.held_value (cell_value[i]),
			.held_valid (cell_valid[i]),
			.carry_value(carry_value[i]),
			.carry_valid(carry_valid[i])
		);
	end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for heap_sorter_core: sends sets of signed values and checks the
// sorted results against its own heapsort of every set. Depends on hps_pkg and the core.
module tb_top;

	localparam int CAPACITY    = hps_pkg::DEF_CAPACITY;
	localparam int VALUE_WIDTH = hps_pkg::DEF_VALUE_WIDTH;
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT    = 30;

	typedef logic signed [VALUE_WIDTH-1:0] sample_t;

	typedef struct {
		sample_t value;
		logic    last;
		logic    overflow;
	} sorted_item_t;

	logic    clk = 1'b0;
	logic    arst_n = 1'b0;
	logic    valid = 1'b0;
	logic    stall;
	sample_t value = '0;
	logic    last = 1'b0;
	logic    valid_res;
	logic    stall_res = 1'b0;
	sample_t value_res;
	logic    last_res;
	logic    overflow;

	// Predictor state: a copy of the store, its fill level and the dropped flag.
	sample_t set_store [1:CAPACITY];
	int      set_fill = 0;
	logic    set_dropped = 1'b0;

	sorted_item_t sorted_q[$];
	int           err_count = 0;
	bit           idle_on = 1'b1;
	int           hold_requests = 0;
	int           hold_served = 0;
	int           hold_left = 0;

	heap_sorter_core #(
		.CAPACITY   (CAPACITY),
		.VALUE_WIDTH(VALUE_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid    (valid),
		.stall    (stall),
		.value    (value),
		.last     (last),
		.valid_res(valid_res),
		.stall_res(stall_res),
		.value_res(value_res),
		.last_res (last_res),
		.overflow (overflow)
	);

	always #1 clk = ~clk;

	// The run is ended here if the core stops making progress.
	initial begin
		#1000000;
		$display("CHECK FAILED");
		$finish;
	end

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t ns: %s", $time, what);
		err_count++;
	endtask

	// Moves the value at node down until neither child is strictly greater.
	function automatic void sift_down(input int node, input int heap_len);
		int      big;
		int      lc;
		bit      done;
		sample_t t;
		done = 1'b0;
		while (!done) begin
			lc  = 2 * node;
			big = node;
			if (lc <= heap_len && set_store[lc] > set_store[big])
				big = lc;
			if (lc + 1 <= heap_len && set_store[lc + 1] > set_store[big])
				big = lc + 1;
			if (big == node) begin
				done = 1'b1;
			end else begin
				t               = set_store[node];
				set_store[node] = set_store[big];
				set_store[big]  = t;
				node            = big;
			end
		end
	endfunction

	// Updates the predicted store for one accepted transfer; a last transfer sorts the set
	// and queues one expected result per stored value.
	function automatic void predict_transfer(input sample_t v, input logic l);
		sorted_item_t item;
		sample_t      t;
		if (set_fill < CAPACITY) begin
			set_fill++;
			set_store[set_fill] = v;
		end else begin
			set_dropped = 1'b1;
		end
		if (l) begin
			for (int i = set_fill / 2; i > 0; i--)
				sift_down(i, set_fill);
			for (int i = set_fill; i > 1; i--) begin
				t            = set_store[1];
				set_store[1] = set_store[i];
				set_store[i] = t;
				sift_down(1, i - 1);
			end
			for (int k = 1; k <= set_fill; k++) begin
				item.value    = set_store[k];
				item.last     = (k == set_fill);
				item.overflow = set_dropped;
				sorted_q.push_back(item);
			end
			set_fill    = 0;
			set_dropped = 1'b0;
		end
	endfunction

	// Offers one value, with a random gap first, and waits for its transfer.
	// Valid is left high so that a following value can go out without a gap.
	task automatic send_value(input sample_t v, input logic l);
		while (idle_on && $urandom_range(99) < IDLE_PCT) begin
			valid <= 1'b0;
			@(posedge clk);
		end
		valid <= 1'b1;
		value <= v;
		last  <= l;
		do
			@(posedge clk);
		while (stall);
		predict_transfer(v, l);
	endtask

	// Sender pause: lowers valid and waits until every expected result has come.
	task automatic wait_sorted_drain();
		valid <= 1'b0;
		do
			@(posedge clk);
		while (sorted_q.size() != 0);
	endtask

	// Mostly full-range values, with a share of small ones so that equal values are common.
	function automatic sample_t random_sample();
		if ($urandom_range(99) < 30)
			return sample_t'($signed($urandom_range(8)) - 4);
		return sample_t'($urandom);
	endfunction

	task automatic send_random_set(input int n);
		for (int i = 1; i <= n; i++)
			send_value(random_sample(), i == n);
	endtask

	// Receiver: random stall, or a long hold-off when one has been requested.
	always @(posedge clk) begin
		if (hold_requests != hold_served) begin
			hold_served = hold_requests;
			hold_left   = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			stall_res <= 1'b1;
		end else begin
			stall_res <= idle_on && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Each result transfer is compared with the oldest expected result.
	always @(posedge clk) begin : check_results
		sorted_item_t exp_item;
		if (arst_n && valid_res && !stall_res) begin
			if (sorted_q.size() == 0) begin
				report_mismatch($sformatf("unexpected result value %0d", value_res));
			end else begin
				exp_item = sorted_q.pop_front();
				if (value_res !== exp_item.value)
					report_mismatch($sformatf("value_res %0d, expected %0d",
						value_res, exp_item.value));
				if (last_res !== exp_item.last)
					report_mismatch($sformatf("last_res %b, expected %b",
						last_res, exp_item.last));
				if (overflow !== exp_item.overflow)
					report_mismatch($sformatf("overflow %b, expected %b",
						overflow, exp_item.overflow));
			end
		end
	end

	// Extremes of the value range, a single-value set, equal values and ordered input.
	task automatic test_directed_sets();
		send_value(sample_t'(-32768), 1'b1);
		send_value(sample_t'(32767), 1'b0);
		send_value(sample_t'(-32768), 1'b0);
		send_value(sample_t'(0), 1'b0);
		send_value(sample_t'(-1), 1'b0);
		send_value(sample_t'(1), 1'b0);
		send_value(sample_t'(-2), 1'b0);
		send_value(sample_t'(16384), 1'b1);
		send_value(sample_t'(5), 1'b0);
		send_value(sample_t'(5), 1'b0);
		send_value(sample_t'(-3), 1'b0);
		send_value(sample_t'(5), 1'b0);
		send_value(sample_t'(5), 1'b0);
		send_value(sample_t'(-3), 1'b1);
		send_value(sample_t'(32767), 1'b0);
		send_value(sample_t'(32767), 1'b1);
		for (int i = 1; i <= 4; i++)
			send_value(sample_t'(i), i == 4);
		for (int i = 4; i >= 1; i--)
			send_value(sample_t'(-i * 1000), i == 1);
		wait_sorted_drain();
	endtask

	// A set that fills the store exactly and whose last value is then dropped.
	task automatic test_store_full();
		send_random_set(CAPACITY + 1);
		wait_sorted_drain();
	endtask

	// Random sets of modest size, with pauses.
	task automatic test_random_sets();
		int sent;
		int n;
		int pick;
		sent = 0;
		while (sent < 25) begin
			pick = $urandom_range(99);
			if (pick < 75)
				n = $urandom_range(12, 1);
			else
				n = $urandom_range(20, 13);
			send_random_set(n);
			sent += n;
			if ($urandom_range(99) < 10)
				wait_sorted_drain();
		end
		wait_sorted_drain();
	endtask

	// A long stretch with neither side idling.
	task automatic test_full_rate();
		idle_on = 1'b0;
		send_random_set(3);
		send_random_set(1);
		send_random_set(12);
		send_random_set(8);
		wait_sorted_drain();
		idle_on = 1'b1;
	endtask

	// The receiver holds off for a long stretch while sets keep coming, so the core stays in its
	// output phase and stalls its input.
	task automatic test_output_holdoff();
		hold_requests++;
		send_random_set(20);
		send_random_set(6);
		wait_sorted_drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_sets();
		test_store_full();
		test_random_sets();
		test_full_rate();
		test_output_holdoff();
		// Let the core settle so that any stray result transfer is seen.
		repeat (3 * CAPACITY) @(posedge clk);
		if (err_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/core/hps_pkg.sv
rtl/core/hps_cell.sv
rtl/core/heap_sorter_core.sv
tb/tb_top.sv
